// File: src/fps_pkg.sv
package fps_pkg;

    // Flight phases, encoded as on the result beat
    typedef enum logic [2:0] {
        PH_GROUND       = 3'd0,
        PH_ARMED        = 3'd1,
        PH_FAST         = 3'd2,
        PH_CONTROLLED   = 3'd3,
        PH_UNCONTROLLED = 3'd4,
        PH_PYRO         = 3'd5,
        PH_STASIS       = 3'd6,
        PH_FLASH        = 3'd7
    } t_phase;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROLS_DELAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUTE_DELAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PYRO_ON_TIME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESTOP_CODE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_CODE        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PYRO_CODE       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_CODE      = 3'd7;

    // Reset values of the configuration registers
    localparam logic signed [15:0] RST_ACCEL_THRESHOLD = 16'sd5242;
    localparam logic [31:0] RST_CONTROLS_DELAY = 32'd1000;
    localparam logic [31:0] RST_CHUTE_DELAY    = 32'd11500;
    localparam logic [31:0] RST_PYRO_ON_TIME   = 32'd1000;
    localparam logic [7:0]  RST_ESTOP_CODE     = 8'd1;
    localparam logic [7:0]  RST_ARM_CODE       = 8'd2;
    localparam logic [7:0]  RST_PYRO_CODE      = 8'd3;
    localparam logic [7:0]  RST_FLASH_CODE     = 8'd4;

    typedef struct packed {
        logic signed [15:0] accel_threshold_raw;
        logic [31:0]        ctrl_delay;
        logic [31:0]        chute_delay;
        logic [31:0]        pyro_on_time;
        logic [7:0]         estop_code;
        logic [7:0]         arm_code;
        logic [7:0]         pyro_code;
        logic [7:0]         flash_code;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        tick_time;
        logic [7:0]         command;
        logic signed [15:0] upward_accel_raw;
        logic               tilt_abort;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  flight_phase;
        logic        pyro_line;
        logic [31:0] control_elapsed;
    } t_out_beat;

endpackage

// File: src/fps_cfg_regs.sv
module fps_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output fps_pkg::t_cfg                    o_cfg
);

    fps_pkg::t_cfg r_cfg;
    fps_pkg::t_cfg n_cfg;

    // Decode the write and update one register
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fps_pkg::CFG_ACCEL_THRESHOLD: n_cfg.accel_threshold_raw = i_cfg_data[15:0];
                fps_pkg::CFG_CONTROLS_DELAY:  n_cfg.ctrl_delay = i_cfg_data;
                fps_pkg::CFG_CHUTE_DELAY:     n_cfg.chute_delay = i_cfg_data;
                fps_pkg::CFG_PYRO_ON_TIME:    n_cfg.pyro_on_time = i_cfg_data;
                fps_pkg::CFG_ESTOP_CODE:      n_cfg.estop_code = i_cfg_data[7:0];
                fps_pkg::CFG_ARM_CODE:        n_cfg.arm_code = i_cfg_data[7:0];
                fps_pkg::CFG_PYRO_CODE:       n_cfg.pyro_code = i_cfg_data[7:0];
                fps_pkg::CFG_FLASH_CODE:      n_cfg.flash_code = i_cfg_data[7:0];
                default:                      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_threshold_raw  <= fps_pkg::RST_ACCEL_THRESHOLD;
            r_cfg.ctrl_delay           <= fps_pkg::RST_CONTROLS_DELAY;
            r_cfg.chute_delay          <= fps_pkg::RST_CHUTE_DELAY;
            r_cfg.pyro_on_time         <= fps_pkg::RST_PYRO_ON_TIME;
            r_cfg.estop_code           <= fps_pkg::RST_ESTOP_CODE;
            r_cfg.arm_code             <= fps_pkg::RST_ARM_CODE;
            r_cfg.pyro_code            <= fps_pkg::RST_PYRO_CODE;
            r_cfg.flash_code           <= fps_pkg::RST_FLASH_CODE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/fps_core.sv
module fps_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  fps_pkg::t_cfg       i_cfg,
    input  fps_pkg::t_in_beat   i_beat,
    output fps_pkg::t_out_beat  o_result
);

    fps_pkg::t_phase r_phase;
    fps_pkg::t_phase n_phase;
    logic [31:0]     r_launch_time;
    logic [31:0]     n_launch_time;
    logic [31:0]     r_pyro_start;
    logic [31:0]     n_pyro_start;
    logic            r_pyro_level;
    logic            n_pyro_level;

    logic        has_cmd;
    logic        is_estop;
    logic        is_pyro;
    logic        launch_hit;
    logic        controls_hit;
    logic        chute_hit;
    logic        pyro_done;
    logic        auto_fire;
    logic [31:0] start_time;

    // Decode the command byte; zero never matches a code
    assign has_cmd  = (i_beat.command != 8'd0);
    assign is_estop = has_cmd && (i_beat.command == i_cfg.estop_code);
    assign is_pyro  = has_cmd && !is_estop && (i_beat.command == i_cfg.pyro_code);

    // Time and launch tests, sums wrap at 32 bits
    assign launch_hit   = (i_beat.upward_accel_raw > i_cfg.accel_threshold_raw);
    assign controls_hit = (i_beat.tick_time > 32'(i_cfg.ctrl_delay + r_launch_time));
    assign chute_hit    = (i_beat.tick_time > 32'(i_cfg.chute_delay + r_launch_time));
    assign pyro_done    = (i_beat.tick_time > 32'(i_cfg.pyro_on_time + r_pyro_start));
    assign auto_fire    = ((r_phase == fps_pkg::PH_CONTROLLED) ||
                           (r_phase == fps_pkg::PH_UNCONTROLLED)) && chute_hit;

    // Next phase: commands first, then the current phase, then tilt demotion
    always_comb begin
        if (is_estop) begin
            n_phase = fps_pkg::PH_STASIS;
        end else if (is_pyro) begin
            n_phase = fps_pkg::PH_PYRO;
        end else begin
            unique case (r_phase) inside
                fps_pkg::PH_GROUND: begin
                    n_phase = (has_cmd && i_beat.command == i_cfg.arm_code) ?
                              fps_pkg::PH_ARMED : fps_pkg::PH_GROUND;
                end
                fps_pkg::PH_ARMED: begin
                    n_phase = launch_hit ? fps_pkg::PH_FAST : fps_pkg::PH_ARMED;
                end
                fps_pkg::PH_FAST: begin
                    n_phase = controls_hit ? fps_pkg::PH_CONTROLLED : fps_pkg::PH_FAST;
                end
                fps_pkg::PH_CONTROLLED,
                fps_pkg::PH_UNCONTROLLED: begin
                    n_phase = chute_hit ? fps_pkg::PH_PYRO : r_phase;
                end
                fps_pkg::PH_PYRO: begin
                    n_phase = pyro_done ? fps_pkg::PH_STASIS : fps_pkg::PH_PYRO;
                end
                fps_pkg::PH_STASIS: begin
                    n_phase = (has_cmd && i_beat.command == i_cfg.flash_code) ?
                              fps_pkg::PH_FLASH : fps_pkg::PH_STASIS;
                end
                default: begin
                    n_phase = fps_pkg::PH_FLASH;
                end
            endcase
            if (i_beat.tilt_abort && n_phase == fps_pkg::PH_CONTROLLED) begin
                n_phase = fps_pkg::PH_UNCONTROLLED;
            end
        end
    end

    // Stored times, pyro line and the result beat
    always_comb begin
        n_launch_time = r_launch_time;
        n_pyro_start  = r_pyro_start;
        n_pyro_level  = r_pyro_level;
        if (!is_estop) begin
            if (is_pyro || auto_fire) begin
                n_pyro_level = 1'b1;
                n_pyro_start = i_beat.tick_time;
            end else if (r_phase == fps_pkg::PH_ARMED && launch_hit) begin
                n_launch_time = i_beat.tick_time;
            end else if (r_phase == fps_pkg::PH_PYRO && pyro_done) begin
                n_pyro_level = 1'b0;
            end
        end
        start_time = 32'(n_launch_time + i_cfg.ctrl_delay);
        o_result.flight_phase    = n_phase;
        o_result.pyro_line       = n_pyro_level;
        o_result.control_elapsed = (i_beat.tick_time > start_time) ?
                                   32'(i_beat.tick_time - start_time) : 32'd0;
    end

    // Advance the state on each processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= fps_pkg::PH_GROUND;
            r_launch_time <= 32'd0;
            r_pyro_start  <= 32'd0;
            r_pyro_level  <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_launch_time <= n_launch_time;
            r_pyro_start  <= n_pyro_start;
            r_pyro_level  <= n_pyro_level;
        end
    end

endmodule

// File: src/flight_phase_sequencer.sv
// Flight phase sequencer.
// Input channel: one beat per control cycle (tick time, command byte, raw upward
// acceleration, tilt abort) on i_in_valid / o_in_stall / i_in_data.
// Output channel: one result beat per input beat (phase, pyro line, ticks since
// controls start) on o_out_valid / i_out_stall / o_out_data, in input order.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data at the edge;
// write only while no beat is in flight.
// Pipeline: two register stages, input register then result register; a beat
// accepted into the input register moves on to the result register when it has room.
// Throughput: one beat per clock while i_out_stall is low; the phase update is a
// single pass of compares and 32-bit adds between the input and result registers.
// Stall: while i_out_stall holds a waiting result, the input register still
// takes one more beat, then o_in_stall rises until the result is taken.
// Reset (synchronous, i_rst_n low): phase ground, stored times zero, pyro line
// released, configuration at its defaults, both stages empty.
module flight_phase_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  fps_pkg::t_in_beat                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output fps_pkg::t_out_beat               o_out_data,
    input  logic                             i_cfg_we,
    input  logic [fps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    fps_pkg::t_cfg      cfg;
    fps_pkg::t_out_beat core_result;

    logic               r_in_valid;
    fps_pkg::t_in_beat  r_in_data;
    logic               r_out_valid;
    fps_pkg::t_out_beat r_out_data;
    logic               out_load;
    logic               in_load;

    fps_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Move a beat from the input register to the result register when there is room
    assign out_load   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = !in_load;

    fps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (out_load),
        .i_cfg    (cfg),
        .i_beat   (r_in_data),
        .o_result (core_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The pyro line only stays on in pyro, stasis or flash
    a_pyro_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.pyro_line) |->
            (r_out_data.flight_phase == fps_pkg::PH_PYRO ||
             r_out_data.flight_phase == fps_pkg::PH_STASIS ||
             r_out_data.flight_phase == fps_pkg::PH_FLASH))
        else $error("pyro line asserted outside pyro, stasis or flash");

    // An empty input register never stalls the sender
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled with empty input register");

    // A new result always comes from a beat held in the input register
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without an input beat");

endmodule
